>>> hdl/timer_min_heap_queue_defines.svh
// assertion macros for the timer heap queue checker
`ifndef TIMER_MIN_HEAP_QUEUE_DEFINES_SVH
`define TIMER_MIN_HEAP_QUEUE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define TMHQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define TMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/tmhq_pkg.sv
// shared types and constants for the timer heap queue
package tmhq_pkg;
  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ID_W = 4;
  localparam int NUM_TIMERS = 16;
  localparam int DL_W = 33;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CHANGE = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_TICK_END = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE = 4'd0, CMD_LOAD = 4'd1, CMD_ADD = 4'd2, CMD_TAKE = 4'd3,
    CMD_CHANGE = 4'd4, CMD_RD_NODE = 4'd5, CMD_RD_KIDS = 4'd6,
    CMD_UP_STEP = 4'd7, CMD_DN_STEP = 4'd8, CMD_TICK_TOP = 4'd9
  } cmd_t;

  typedef struct packed {
    logic present;
    logic full;
    logic idx_ok;
    logic up_swap;
    logic dn_swap;
    logic at_root;
    logic moved;
    logic change_up;
    logic change_dn;
    logic top_due;
    logic empty;
  } dp_status_t;
endpackage

>>> hdl/tmhq_datapath.sv
// heap storage, timer slot table, compare and swap logic
module tmhq_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  tmhq_pkg::cmd_t        cmd,
  input  logic [1:0]            op_in,
  input  logic [3:0]            id_in,
  input  logic [31:0]           time_in,
  input  logic [31:0]           delay_in,
  input  logic [31:0]           max_wait,
  output tmhq_pkg::dp_status_t  stat,
  output logic [3:0]            top_id,
  output logic [32:0]           wait_out
);
  import tmhq_pkg::*;

  logic [ID_W-1:0]  ids [CAPACITY];
  logic [DL_W-1:0]  dls [CAPACITY];
  logic [IDX_W-1:0] slot [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] valid;
  logic [CNT_W-1:0] count;

  logic [ID_W-1:0]  id_r;
  logic [31:0]      now_r;
  logic [DL_W-1:0]  dl_r;
  logic [IDX_W-1:0] cur;
  logic [DL_W-1:0]  cur_dl, par_dl, l_dl, r_dl;
  logic [ID_W-1:0]  cur_id, par_id, l_id, r_id;
  logic             l_ok, r_ok;
  logic [IDX_W-1:0] par_idx;
  logic [IDX_W:0]   l_idx_w, r_idx_w;
  logic             moved;

  assign par_idx = (cur - 1'b1) >> 1;
  assign l_idx_w = {cur, 1'b1};
  assign r_idx_w = {cur, 1'b1} + 1'b1;

  logic pick_r, dn_swap, up_swap;
  logic [IDX_W-1:0] kid;
  assign pick_r = r_ok && (r_dl < l_dl);
  assign kid = pick_r ? r_idx_w[IDX_W-1:0] : l_idx_w[IDX_W-1:0];
  assign dn_swap = l_ok && ((pick_r ? r_dl : l_dl) < cur_dl);
  assign up_swap = (cur != '0) && (cur_dl < par_dl);

  assign stat.present = valid[id_r];
  assign stat.full = (count >= CNT_W'(CAPACITY));
  assign stat.idx_ok = ({1'b0, slot[id_r]} < count);
  assign stat.up_swap = up_swap;
  assign stat.dn_swap = dn_swap;
  assign stat.at_root = (cur == '0);
  assign stat.moved = moved;
  assign stat.change_up = dl_r < cur_dl;
  assign stat.change_dn = dl_r > cur_dl;
  assign stat.top_due = (count != '0) && (dls[0] <= {1'b0, now_r});
  assign stat.empty = (count == '0);
  assign top_id = ids[0];

  always_comb begin
    if (count == '0) wait_out = {1'b0, max_wait};
    else if (dls[0] <= {1'b0, now_r}) wait_out = '0;
    else wait_out = dls[0] - {1'b0, now_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else begin
      unique case (cmd)
        CMD_LOAD: begin
          id_r <= (op_in == OP_TICK) ? ids[0] : id_in;
          now_r <= time_in;
          dl_r <= {1'b0, time_in} + {1'b0, delay_in};
        end
        CMD_ADD: begin
          ids[count[IDX_W-1:0]] <= id_r;
          dls[count[IDX_W-1:0]] <= dl_r;
          slot[id_r] <= count[IDX_W-1:0];
          valid[id_r] <= 1'b1;
          count <= count + 1'b1;
          cur <= count[IDX_W-1:0];
          moved <= 1'b1;
        end
        CMD_TAKE: begin
          valid[id_r] <= 1'b0;
          count <= count - 1'b1;
          cur <= slot[id_r];
          moved <= ({1'b0, slot[id_r]} < count - 1'b1);
          if ({1'b0, slot[id_r]} < count - 1'b1) begin
            ids[slot[id_r]] <= ids[count[IDX_W-1:0] - 1'b1];
            dls[slot[id_r]] <= dls[count[IDX_W-1:0] - 1'b1];
            slot[ids[count[IDX_W-1:0] - 1'b1]] <= slot[id_r];
          end
        end
        CMD_CHANGE: dls[cur] <= dl_r;
        CMD_RD_NODE: cur <= slot[id_r];
        CMD_UP_STEP: begin
          ids[cur] <= par_id; dls[cur] <= par_dl;
          ids[par_idx] <= cur_id; dls[par_idx] <= cur_dl;
          slot[par_id] <= cur; slot[cur_id] <= par_idx;
          cur <= par_idx;
        end
        CMD_DN_STEP: begin
          ids[cur] <= pick_r ? r_id : l_id;
          dls[cur] <= pick_r ? r_dl : l_dl;
          ids[kid] <= cur_id; dls[kid] <= cur_dl;
          slot[pick_r ? r_id : l_id] <= cur; slot[cur_id] <= kid;
          cur <= kid;
        end
        CMD_TICK_TOP: id_r <= ids[0];
        default: ;
      endcase
    end
  end

  // registered reads of the current node, its parent and its children
  always_ff @(posedge clk) begin
    cur_dl <= dls[cur];
    cur_id <= ids[cur];
    par_dl <= dls[par_idx];
    par_id <= ids[par_idx];
    l_ok <= l_idx_w < (IDX_W+1)'(count);
    r_ok <= r_idx_w < (IDX_W+1)'(count);
    l_dl <= dls[l_idx_w[IDX_W-1:0]];
    l_id <= ids[l_idx_w[IDX_W-1:0]];
    r_dl <= dls[r_idx_w[IDX_W-1:0]];
    r_id <= ids[r_idx_w[IDX_W-1:0]];
  end
endmodule

>>> hdl/tmhq_control.sv
// sequencer for heap operations and result hand-off
module tmhq_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op_in,
  output tmhq_pkg::cmd_t       cmd,
  input  tmhq_pkg::dp_status_t stat,
  input  logic [3:0]           top_id,
  input  logic [32:0]          wait_out,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [3:0]           id_out,
  output logic                 head,
  output logic [1:0]           status,
  output logic [32:0]          wait_time,
  output logic                 last
);
  import tmhq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_DECODE = 10'b0000000010, S_RD = 10'b0000000100,
    S_UP = 10'b0000001000, S_DN = 10'b0000010000, S_EMIT = 10'b0000100000,
    S_CHG = 10'b0001000000, S_CHG2 = 10'b0010000000, S_TICK = 10'b0100000000,
    S_WAIT = 10'b1000000000
  } state_t;

  state_t state;
  logic [1:0] op;
  logic up_only, tick_more, loaded;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = CMD_NONE;
    if (state == S_IDLE && in_valid && in_ready) cmd = CMD_LOAD;
    else if (state == S_DECODE) begin
      priority if (op == OP_ADD && !stat.present && !stat.full) cmd = CMD_ADD;
      else if (op == OP_REMOVE && stat.present) cmd = CMD_TAKE;
      else if (op == OP_CHANGE && stat.present) cmd = CMD_RD_NODE;
      else cmd = CMD_NONE;
    end else if (state == S_CHG2 && (stat.change_up || stat.change_dn)) cmd = CMD_CHANGE;
    else if (state == S_UP && loaded && stat.up_swap) cmd = CMD_UP_STEP;
    else if (state == S_DN && loaded && stat.dn_swap) cmd = CMD_DN_STEP;
    // tick loop: pick up the new heap top before the next expiry check
    else if (tick_more && ((state == S_RD && !stat.moved) ||
                           (state == S_DN && loaded && !stat.dn_swap))) cmd = CMD_TICK_TOP;
    else if (state == S_TICK && !out_valid && stat.top_due) cmd = CMD_TAKE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      loaded <= 1'b0;
      op <= OP_ADD;
      up_only <= 1'b0;
      tick_more <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      loaded <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd == CMD_LOAD) begin
          op <= op_in;
          state <= S_DECODE;
        end
        S_DECODE: begin
          kind <= KIND_DONE; id_out <= '0; head <= 1'b0;
          status <= ST_OK; wait_time <= '0; last <= 1'b1;
          up_only <= 1'b0; tick_more <= 1'b0;
          unique case (op)
            OP_ADD: begin
              if (stat.present) begin status <= ST_PRESENT; state <= S_EMIT; end
              else if (stat.full) begin status <= ST_FULL; state <= S_EMIT; end
              else begin up_only <= 1'b1; state <= S_UP; end
            end
            OP_REMOVE: begin
              if (!stat.present) begin status <= ST_ABSENT; state <= S_EMIT; end
              else state <= S_RD;
            end
            OP_CHANGE: begin
              if (!stat.present) begin status <= ST_ABSENT; state <= S_EMIT; end
              else state <= S_CHG;
            end
            default: state <= S_TICK;
          endcase
        end
        S_RD: state <= stat.moved ? S_UP : (tick_more ? S_TICK : S_EMIT);
        S_CHG: state <= S_CHG2;
        S_CHG2: begin
          if (!stat.idx_ok || !(stat.change_up || stat.change_dn)) state <= S_EMIT;
          else if (stat.change_up) begin up_only <= 1'b1; state <= S_UP; end
          else state <= S_DN;
        end
        S_UP: begin
          if (!loaded) loaded <= 1'b1;
          else if (!stat.up_swap) begin
            if (up_only) begin
              head <= stat.at_root;
              state <= S_EMIT;
            end else state <= S_DN;
          end
        end
        S_DN: begin
          if (!loaded) loaded <= 1'b1;
          else if (!stat.dn_swap) state <= tick_more ? S_TICK : S_EMIT;
        end
        S_EMIT: if (!out_valid) begin
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: if (!out_valid || out_ready) state <= S_IDLE;
        S_TICK: if (!out_valid) begin
          tick_more <= 1'b1;
          out_valid <= 1'b1;
          if (stat.top_due) begin
            kind <= KIND_EXPIRED; id_out <= top_id; wait_time <= '0; last <= 1'b0;
            state <= S_RD;
          end else begin
            kind <= KIND_TICK_END; id_out <= '0; wait_time <= wait_out; last <= 1'b1;
            state <= S_WAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/timer_min_heap_queue.sv
// top level of the timer heap queue
// Timer queue of up to 16 timers kept as a binary min-heap of 33-bit
// deadlines. One request is handled at a time: after decode, each sift level
// is a registered read of node, parent and children, then one compare and
// swap; add, remove and change sift a node, and a tick removes each expired
// timer in the same way, with one result each, plus one end result. The heap
// arrays are read and written by a single sift datapath. Results are held in
// an output register until taken.
module timer_min_heap_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // timer_id, current_time, delay, pad
  input  logic [1:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // timer_id_out, became_head, status, wait_time
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import tmhq_pkg::*;

  cmd_t cmd;
  dp_status_t stat;
  logic [31:0] max_wait;
  logic [3:0] top_id, id_out;
  logic [32:0] wait_out, wait_time;
  logic head;
  logic [1:0] status;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_wait <= 32'd1000;
    else if (cfg_valid) max_wait <= cfg_data;
  end

  tmhq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .op_in(s_axis_tuser),
    .id_in(s_axis_tdata[3:0]), .time_in(s_axis_tdata[35:4]),
    .delay_in(s_axis_tdata[67:36]), .max_wait(max_wait), .stat(stat),
    .top_id(top_id), .wait_out(wait_out)
  );

  tmhq_control u_ctl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op_in(s_axis_tuser), .cmd(cmd), .stat(stat), .top_id(top_id),
    .wait_out(wait_out), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .kind(m_axis_tuser), .id_out(id_out), .head(head), .status(status),
    .wait_time(wait_time), .last(m_axis_tlast)
  );

  assign m_axis_tdata = {wait_time, status, head, id_out};
endmodule

>>> hdl/tmhq_checker.sv
// port-level checks for the timer heap queue
`include "timer_min_heap_queue_defines.svh"
module tmhq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import tmhq_pkg::*;

  `TMHQ_ASSERT_IMP(a_end_last, m_axis_tvalid && m_axis_tuser != KIND_EXPIRED, m_axis_tlast,
    "non-expiry result without last")
  `TMHQ_ASSERT_IMP(a_exp_notlast, m_axis_tvalid && m_axis_tuser == KIND_EXPIRED, !m_axis_tlast,
    "expiry marked last")
  `TMHQ_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "request taken while busy")
  `TMHQ_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata),
    "result changed while stalled")
endmodule

bind timer_min_heap_queue tmhq_checker u_chk (.*);

>>> test/testbench.sv
// self-checking testbench for the timer heap queue
import tmhq_pkg::*;

typedef struct {
  logic [1:0]  kind;
  logic [3:0]  tid;
  logic        head;
  logic [1:0]  status;
  logic [32:0] wait_ms;
  logic        last;
} timer_result_t;

class timer_scoreboard;
  logic [3:0]  ids[CAPACITY];
  logic [32:0] deadlines[CAPACITY];
  int          slot[NUM_TIMERS];
  bit          present[NUM_TIMERS];
  int          count;
  logic [31:0] max_wait;
  timer_result_t pending[$];
  int errors;

  function new();
    count = 0;
    max_wait = 32'd1000;
    errors = 0;
    foreach (present[i]) begin
      present[i] = 0;
      slot[i] = 0;
    end
  endfunction

  function void push(logic [1:0] kind, logic [3:0] tid, logic head, logic [1:0] st,
                     logic [32:0] w, logic last);
    timer_result_t r;
    r.kind = kind;
    r.tid = tid;
    r.head = head;
    r.status = st;
    r.wait_ms = w;
    r.last = last;
    pending.insert(pending.size(), r);
  endfunction

  function void swap_nodes(int a, int b);
    logic [3:0]  t;
    logic [32:0] d;
    t = ids[a];
    d = deadlines[a];
    ids[a] = ids[b];
    deadlines[a] = deadlines[b];
    ids[b] = t;
    deadlines[b] = d;
    slot[ids[a]] = a;
    slot[ids[b]] = b;
  endfunction

  function int raise(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (deadlines[i] < deadlines[p]) begin
        swap_nodes(i, p);
        i = p;
      end else break;
    end
    return i;
  endfunction

  function void lower(int i);
    int l;
    int m;
    forever begin
      l = 2 * i + 1;
      m = i;
      if (l < count && deadlines[l] < deadlines[m]) m = l;
      if (l + 1 < count && deadlines[l + 1] < deadlines[m]) m = l + 1;
      if (m == i) break;
      swap_nodes(i, m);
      i = m;
    end
  endfunction

  function void drop(int id);
    int idx;
    idx = slot[id];
    present[id] = 0;
    if (count == 0 || idx >= count) return;
    count--;
    if (idx < count) begin
      ids[idx] = ids[count];
      deadlines[idx] = deadlines[count];
      slot[ids[idx]] = idx;
      lower(raise(idx));
    end
  endfunction

  // works out the results that one accepted request causes
  function void note_request(logic [1:0] op, logic [3:0] id, logic [31:0] now,
                             logic [31:0] dly);
    logic [32:0] dl;
    int pos;
    bit head;
    logic [32:0] w;
    dl = {1'b0, now} + {1'b0, dly};
    case (op)
      OP_ADD: begin
        if (present[id]) push(KIND_DONE, 0, 0, ST_PRESENT, 0, 1);
        else if (count >= CAPACITY) push(KIND_DONE, 0, 0, ST_FULL, 0, 1);
        else begin
          ids[count] = id;
          deadlines[count] = dl;
          slot[id] = count;
          present[id] = 1;
          count++;
          pos = raise(count - 1);
          push(KIND_DONE, 0, pos == 0, ST_OK, 0, 1);
        end
      end
      OP_REMOVE: begin
        if (!present[id]) push(KIND_DONE, 0, 0, ST_ABSENT, 0, 1);
        else begin
          drop(id);
          push(KIND_DONE, 0, 0, ST_OK, 0, 1);
        end
      end
      OP_CHANGE: begin
        if (!present[id]) push(KIND_DONE, 0, 0, ST_ABSENT, 0, 1);
        else begin
          head = 0;
          pos = slot[id];
          if (deadlines[pos] < dl) begin
            deadlines[pos] = dl;
            lower(pos);
          end else if (deadlines[pos] > dl) begin
            deadlines[pos] = dl;
            head = raise(pos) == 0;
          end
          push(KIND_DONE, 0, head, ST_OK, 0, 1);
        end
      end
      default: begin
        while (count > 0 && deadlines[0] <= {1'b0, now}) begin
          push(KIND_EXPIRED, ids[0], 0, ST_OK, 0, 0);
          drop(ids[0]);
        end
        if (count == 0) w = {1'b0, max_wait};
        else w = deadlines[0] - {1'b0, now};
        push(KIND_TICK_END, 0, 0, ST_OK, w, 1);
      end
    endcase
  endfunction

  function void check_result(logic [1:0] kind, logic [3:0] tid, logic head,
                             logic [1:0] st, logic [32:0] w, logic last);
    timer_result_t e;
    if (pending.size() == 0) begin
      $error("result with nothing pending: kind %0d", kind);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (kind !== e.kind) begin
      $error("kind: expected %0d, actual %0d", e.kind, kind);
      errors++;
    end
    if (tid !== e.tid) begin
      $error("timer_id_out: expected %0d, actual %0d", e.tid, tid);
      errors++;
    end
    if (head !== e.head) begin
      $error("became_head: expected %0d, actual %0d", e.head, head);
      errors++;
    end
    if (st !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, st);
      errors++;
    end
    if (w !== e.wait_ms) begin
      $error("wait_time: expected %0d, actual %0d", e.wait_ms, w);
      errors++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, actual %0d", e.last, last);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  timer_scoreboard timers;
  int  idle_cycles;
  bit  hold_off;
  bit  out_steady;
  logic [31:0] clock_ms;

  timer_min_heap_queue dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, with a long hold-off or a steady ready on request
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 0;
    else if (out_steady) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 99) < 70);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      timers.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[4],
                          m_axis_tdata[6:5], m_axis_tdata[39:7], m_axis_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // valid stays high after the accepting edge until the next falling edge
  task automatic send(logic [1:0] op, logic [3:0] id, logic [31:0] now,
                      logic [31:0] dly, bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    @(negedge clk);
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0000, dly, now, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    timers.note_request(op, id, now, dly);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (timers.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_max_wait(logic [31:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timers.max_wait = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_request();
    int r;
    logic [31:0] dly;
    r = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 60);
    dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120);
    if (r < 40) send(OP_ADD, 4'($urandom_range(0, 15)), clock_ms, dly);
    else if (r < 55) send(OP_REMOVE, 4'($urandom_range(0, 15)), clock_ms, dly);
    else if (r < 75) send(OP_CHANGE, 4'($urandom_range(0, 15)), clock_ms, dly);
    else send(OP_TICK, 4'($urandom), clock_ms, $urandom);
  endtask

  initial begin
    timers = new();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 0;
    cfg_data = '0;
    hold_off = 0;
    out_steady = 0;
    idle_cycles = 0;
    clock_ms = 32'd100;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty tick, absent timer, extremes, duplicates, full heap
    send(OP_TICK, 4'd5, 32'd0, 32'hFFFF_FFFF);
    send(OP_REMOVE, 4'd3, 32'd0, 32'd0);
    send(OP_CHANGE, 4'd3, 32'd0, 32'd0);
    send(OP_ADD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(OP_ADD, 4'd15, 32'd0, 32'd1);
    send(OP_ADD, 4'd0, 32'd0, 32'd0);
    send(OP_ADD, 4'd7, 32'd0, 32'd0);
    send(OP_CHANGE, 4'd7, 32'd0, 32'd0);
    send(OP_CHANGE, 4'd15, 32'd0, 32'd5);
    send(OP_CHANGE, 4'd0, 32'd10, 32'd20);
    send(OP_REMOVE, 4'd7, 32'd0, 32'd0);
    for (int i = 1; i < 15; i++)
      if (i != 7) send(OP_ADD, 4'(i), 32'd50, 32'(100 - i * 3));
    send(OP_ADD, 4'd7, 32'd1, 32'd1);
    send(OP_ADD, 4'd7, 32'd1, 32'd1);
    send(OP_TICK, 4'd0, 32'd60, 32'd0);
    send(OP_TICK, 4'd0, 32'hFFFF_FFFF, 32'd0);

    write_max_wait(32'hFFFF_FFFF);
    send(OP_TICK, 4'd0, 32'd0, 32'd0);

    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 16; i++)
        send(OP_ADD, 4'(i), clock_ms, $urandom_range(0, 30), 1);
    join
    send(OP_TICK, 4'd0, clock_ms + 40, 32'd0, 1);
    write_max_wait(32'd0);

    for (int n = 0; n < 75; n++) begin
      if (n == 25) write_max_wait($urandom);
      if (n == 50) begin
        drain();
        out_steady = 1;
      end
      if (n == 65) out_steady = 0;
      random_request();
    end
    send(OP_TICK, 4'd0, 32'hFFFF_FFFF, 32'd0);
    drain();
    if (timers.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
